/* sv/srmapc_pkg.sv */
package srmapc_pkg;

   // Default width of the angle registers, the step and the accumulators.
   localparam int ANGLE_BITS_DEFAULT = 16;

   // The block drives three motor phases from three capture lines.
   localparam int NUM_PHASES = 3;

   // Run mode codes of an input word.
   typedef enum logic [1:0] {
      MODE_STOP     = 2'd0,
      MODE_FORWARD  = 2'd1,
      MODE_REVERSE  = 2'd2,
      MODE_REGULATE = 2'd3
   } mode_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_ON_ANGLE   = 2'd0,
      CSR_OFF_ANGLE  = 2'd1,
      CSR_COMM_ANGLE = 2'd2
   } csr_index_type;

   // Capture line that arms each phase, per direction of rotation.
   localparam logic [1:0] FWD_LINE [NUM_PHASES] = '{2'd0, 2'd2, 2'd1};
   localparam logic [1:0] RVS_LINE [NUM_PHASES] = '{2'd1, 2'd0, 2'd2};

   // Classification of one armed phase for the current tick.
   typedef struct packed {
      logic run;       // Phase conducts.
      logic commute;   // Phase is in the step-commutation condition.
      logic wrap;      // Commutation angle reached: clear and disarm.
   } phase_flags_type;

endpackage

/* sv/srmapc_if.sv */
// Input channel: one control tick per word.
interface srmapc_req_if
   import srmapc_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            run_mode;
   logic [2:0]            capture_events;
   logic [ANGLE_BITS-1:0] angle_step;

   modport source (output valid, output run_mode, output capture_events,
                   output angle_step, input ready);
   modport sink (input valid, input run_mode, input capture_events,
                 input angle_step, output ready);
endinterface

// Result channel: one word of phase flags per tick.
interface srmapc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [2:0] run_flags;
   logic [2:0] step_commute_flags;
   logic       position_active;

   modport source (output valid, output run_flags, output step_commute_flags,
                   output position_active, input ready);
   modport sink (input valid, input run_flags, input step_commute_flags,
                 input position_active, output ready);
endinterface

/* sv/srmapc_phase.sv */
// Angle accumulator step and window classification of one phase.
module srmapc_phase
   import srmapc_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic [ANGLE_BITS-1:0] angle,
   input  logic [ANGLE_BITS-1:0] step,
   input  logic [ANGLE_BITS-1:0] on_angle,
   input  logic [ANGLE_BITS-1:0] off_angle,
   input  logic [ANGLE_BITS-1:0] comm_angle,
   input  logic                  forward,
   output logic [ANGLE_BITS-1:0] angle_next,
   output phase_flags_type       flags
);

   logic [ANGLE_BITS:0] sum;

   // The sum keeps its carry so it never wraps.
   assign sum = {1'b0, angle} + {1'b0, step};

   // The first window that holds decides, in the order on, off, commutation.
   always_comb begin
      flags = '0;
      if (sum < {1'b0, on_angle}) begin
         flags.commute = forward;
      end else if (sum < {1'b0, off_angle}) begin
         flags.run = 1'b1;
      end else if (sum < {1'b0, comm_angle}) begin
         flags = '0;
      end else begin
         flags.commute = 1'b1;
         flags.wrap    = 1'b1;
      end
   end

   // A sum past every window is at or above the commutation angle, so the
   // stored accumulator always fits in the angle width.
   assign angle_next = flags.wrap ? '0 : sum[ANGLE_BITS-1:0];

endmodule

/* sv/srm_angle_position_commutator.sv */
// Angle-position commutator for a three-phase switched-reluctance motor. Each
// input word is one control tick: run mode, capture events and angle step.
// Capture events arm their lines; each armed phase advances its accumulator
// by the step and reports conduct and step-commutation flags against the on,
// off and commutation angles. The block takes one word per clock cycle while
// the result register is empty or being emptied; an accepted word passes the
// input register, then the phase state, which doubles as the result register.
// Ready drops only while a result waits to be taken and the input register is
// full. The user must write the three angle registers through the csr port
// while no tick is in flight; the block itself does not enforce this.
module srm_angle_position_commutator
   import srmapc_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   srmapc_req_if.sink            req,
   srmapc_rsp_if.source          rsp,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [ANGLE_BITS-1:0] csr_data
);

   // Configuration registers.
   logic [ANGLE_BITS-1:0] on_angle_ff, on_angle_in;
   logic [ANGLE_BITS-1:0] off_angle_ff, off_angle_in;
   logic [ANGLE_BITS-1:0] comm_angle_ff, comm_angle_in;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            mode_ff, mode_in;
   logic [2:0]            caps_ff, caps_in;
   logic [ANGLE_BITS-1:0] step_ff, step_in;

   // Phase state; the flag registers also form the result word.
   logic [ANGLE_BITS-1:0] angle_ff [NUM_PHASES];
   logic [ANGLE_BITS-1:0] angle_in [NUM_PHASES];
   logic [2:0]            armed_ff, armed_in;
   logic [2:0]            run_ff, run_in;
   logic [2:0]            comm_ff, comm_in;
   logic                  active_ff, active_in;
   logic                  out_valid_ff, out_valid_in;

   logic                  advance;
   logic                  forward;
   mode_type              mode;
   logic [2:0]            armed_set;
   logic [1:0]            line [NUM_PHASES];
   logic [2:0]            armed_now;
   logic [2:0]            disarm;
   logic [ANGLE_BITS-1:0] angle_next [NUM_PHASES];
   phase_flags_type       flags [NUM_PHASES];

   // Handshake: the tick in the input register moves on when the result
   // register is empty or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign rsp.valid              = out_valid_ff;
   assign rsp.run_flags          = run_ff;
   assign rsp.step_commute_flags = comm_ff;
   assign rsp.position_active    = active_ff;

   // Configuration writes.
   always_comb begin
      on_angle_in   = on_angle_ff;
      off_angle_in  = off_angle_ff;
      comm_angle_in = comm_angle_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ON_ANGLE:   on_angle_in   = csr_data;
            CSR_OFF_ANGLE:  off_angle_in  = csr_data;
            CSR_COMM_ANGLE: comm_angle_in = csr_data;
            default:        on_angle_in   = on_angle_ff;
         endcase
      end
   end

   // Input register loads whenever it has room.
   always_comb begin
      in_valid_in = in_valid_ff;
      mode_in     = mode_ff;
      caps_in     = caps_ff;
      step_in     = step_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         mode_in     = req.run_mode;
         caps_in     = req.capture_events;
         step_in     = req.angle_step;
      end
   end

   // Arming happens first, then each phase looks up its capture line.
   assign mode      = mode_type'(mode_ff);
   assign forward   = (mode == MODE_FORWARD);
   assign armed_set = armed_ff | caps_ff;

   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         line[i]      = forward ? FWD_LINE[i] : RVS_LINE[i];
         armed_now[i] = armed_set[line[i]];
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_PHASES; g++) begin : g_phase
         srmapc_phase #(
            .ANGLE_BITS (ANGLE_BITS)
         ) u_phase (
            .angle      (angle_ff[g]),
            .step       (step_ff),
            .on_angle   (on_angle_ff),
            .off_angle  (off_angle_ff),
            .comm_angle (comm_angle_ff),
            .forward    (forward),
            .angle_next (angle_next[g]),
            .flags      (flags[g])
         );
      end
   endgenerate

   // Next phase state for the tick that moves to the result register.
   always_comb begin
      angle_in     = angle_ff;
      armed_in     = armed_ff;
      run_in       = run_ff;
      comm_in      = comm_ff;
      active_in    = active_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      disarm       = '0;
      if (advance) begin
         out_valid_in = 1'b1;
         active_in    = 1'b1;
         case (mode)
            MODE_STOP: begin
               run_in    = '0;
               comm_in   = '0;
               active_in = 1'b0;
            end
            MODE_FORWARD, MODE_REVERSE: begin
               for (int i = 0; i < NUM_PHASES; i++) begin
                  if (armed_now[i]) begin
                     run_in[i]   = flags[i].run;
                     comm_in[i]  = flags[i].commute;
                     angle_in[i] = angle_next[i];
                     if (flags[i].wrap) begin
                        disarm[line[i]] = 1'b1;
                     end
                  end
               end
            end
            default: begin
               active_in = 1'b1;
            end
         endcase
         armed_in = armed_set & ~disarm;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         on_angle_ff   <= '0;
         off_angle_ff  <= '0;
         comm_angle_ff <= '0;
         in_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_PHASES; i++) begin
            angle_ff[i] <= '0;
         end
         armed_ff      <= '0;
         run_ff        <= '0;
         comm_ff       <= '0;
         active_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         on_angle_ff   <= on_angle_in;
         off_angle_ff  <= off_angle_in;
         comm_angle_ff <= comm_angle_in;
         in_valid_ff   <= in_valid_in;
         angle_ff      <= angle_in;
         armed_ff      <= armed_in;
         run_ff        <= run_in;
         comm_ff       <= comm_in;
         active_ff     <= active_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Input payload register needs no reset.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      caps_ff <= caps_in;
      step_ff <= step_in;
   end

   // A phase never conducts while in the step-commutation condition.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.run_flags & rsp.step_commute_flags) == 3'b000))
      else $error("phase both conducting and in step commutation");

   // A stopped block reports no phase flags.
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.position_active) |->
         (rsp.run_flags == 3'b000 && rsp.step_commute_flags == 3'b000))
      else $error("flags set while position control is inactive");

   // A full input register behind a stalled result must hold off new words.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("input accepted while the pipeline is full and stalled");

   // A result taken with no tick behind it leaves the result register empty.
   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !in_valid_ff) |=> !rsp.valid)
      else $error("result repeated after it was taken");

endmodule
